/* rtl/core/dlct_pkg.sv */
// ----------------------------------------------------------------------------
// dlct_pkg
// shared widths, mode codes and the car id range check of the chain table
// ----------------------------------------------------------------------------
package dlct_pkg;

    localparam int CAR_W        = 7;
    localparam int POS_W        = 6;
    localparam int MODE_W       = 2;
    localparam int NUM_CARS_DEF = 64;

    localparam logic [MODE_W-1:0] MODE_CONNECT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DISCONNECT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY      = 2'd2;

    // true for a car id within 1..num_cars
    function automatic logic car_ok(input logic [CAR_W-1:0] car,
                                    input logic [CAR_W-1:0] num_cars);
        car_ok = (car != '0) && (car <= num_cars);
    endfunction

endpackage

/* rtl/core/dlct_link_mem.sv */
// ----------------------------------------------------------------------------
// dlct_link_mem
// one link table: synchronous memory with one write and one registered read
// port; an entry never written reads back as its own index
// ----------------------------------------------------------------------------
module dlct_link_mem #(
    parameter int NUM_CARS = dlct_pkg::NUM_CARS_DEF,
    parameter int AW       = $clog2(NUM_CARS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [dlct_pkg::CAR_W-1:0] i_wr_data,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [dlct_pkg::CAR_W-1:0] o_rd_data
);

    localparam int DEPTH = NUM_CARS + 1;

    logic [dlct_pkg::CAR_W-1:0] r_mem [DEPTH];
    logic                       r_valid [DEPTH];
    logic [dlct_pkg::CAR_W-1:0] r_rd_data;
    logic [AW-1:0]              r_rd_addr;
    logic                       r_rd_hit;
    logic                       rd_in_range;

    assign rd_in_range = (int'(i_rd_addr) < DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_rd_addr <= i_rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_hit <= rd_in_range && r_valid[i_rd_addr];
        end
    end

    // unwritten entry links to itself
    assign o_rd_data = r_rd_hit ? r_rd_data : dlct_pkg::CAR_W'(r_rd_addr);

endmodule

/* rtl/core/doubly_linked_chain_table_core.sv */
// ----------------------------------------------------------------------------
// doubly_linked_chain_table_core
// front and rear link tables for cars 1..NUM_CARS with connect, disconnect
// and a query that walks to the head and emits the chain in order
// ----------------------------------------------------------------------------
//  channel   | signals                                  | handshake
//  ----------+------------------------------------------+---------------------
//  request   | i_mode, i_car_a, i_car_b                 | start high, busy low
//  result    | o_car_id, o_position, o_last_flag        | o_result_valid, 1 cyc
//
// connect and disconnect never raise busy.
// a query does one link memory read per step, front walk then rear walk.
// results leave one per cycle during the rear walk, the last with o_last_flag.
// reset (synchronous, active low) marks every link entry unwritten, so each
// car is its own end at once; no clearing pass. the receiver cannot stall.
// ----------------------------------------------------------------------------
module doubly_linked_chain_table_core #(
    parameter int NUM_CARS = dlct_pkg::NUM_CARS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [dlct_pkg::MODE_W-1:0] i_mode,
    input  logic [dlct_pkg::CAR_W-1:0]  i_car_a,
    input  logic [dlct_pkg::CAR_W-1:0]  i_car_b,
    output logic                        o_result_valid,
    output logic [dlct_pkg::CAR_W-1:0]  o_car_id,
    output logic [dlct_pkg::POS_W-1:0]  o_position,
    output logic                        o_last_flag
);

    localparam int AW = $clog2(NUM_CARS + 1);
    localparam int SW = $clog2(NUM_CARS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FRONT = 2'd1;
    localparam logic [1:0] S_REAR  = 2'd2;

    localparam logic [dlct_pkg::CAR_W-1:0] N_CARS = dlct_pkg::CAR_W'(NUM_CARS);

    logic [1:0]                  r_state, n_state;
    logic [dlct_pkg::CAR_W-1:0]  r_cur, n_cur;
    logic [SW-1:0]               r_steps, n_steps;
    logic [dlct_pkg::POS_W-1:0]  r_pos, n_pos;
    logic                        r_out_valid, n_out_valid;
    logic [dlct_pkg::CAR_W-1:0]  r_car_id, n_car_id;
    logic [dlct_pkg::POS_W-1:0]  r_position, n_position;
    logic                        r_last, n_last;

    logic                        accept;
    logic                        ids_ok;
    logic                        link_wr;
    logic [AW-1:0]               front_wr_addr, rear_wr_addr;
    logic [dlct_pkg::CAR_W-1:0]  front_wr_data, rear_wr_data;
    logic [AW-1:0]               front_rd_addr, rear_rd_addr;
    logic [dlct_pkg::CAR_W-1:0]  front_d, rear_d;
    logic                        front_go, rear_go;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign ids_ok = dlct_pkg::car_ok(i_car_a, N_CARS) && dlct_pkg::car_ok(i_car_b, N_CARS);

    // connect and disconnect write both tables in the accept cycle
    assign link_wr = accept && ids_ok &&
                     ((i_mode == dlct_pkg::MODE_CONNECT) ||
                      (i_mode == dlct_pkg::MODE_DISCONNECT));
    assign front_wr_addr = i_car_b[AW-1:0];
    assign rear_wr_addr  = i_car_a[AW-1:0];
    assign front_wr_data = (i_mode == dlct_pkg::MODE_CONNECT) ? i_car_a : i_car_b;
    assign rear_wr_data  = (i_mode == dlct_pkg::MODE_CONNECT) ? i_car_b : i_car_a;

    // next read follows the link just returned, one step a cycle
    assign front_rd_addr = (r_state == S_IDLE) ? i_car_a[AW-1:0] : front_d[AW-1:0];
    assign rear_rd_addr  = (r_state == S_REAR) ? rear_d[AW-1:0] : r_cur[AW-1:0];

    assign front_go = (r_steps != SW'(NUM_CARS)) && (front_d != r_cur) &&
                      dlct_pkg::car_ok(front_d, N_CARS);
    assign rear_go  = (r_pos != dlct_pkg::POS_W'(NUM_CARS - 1)) && (rear_d != r_cur) &&
                      dlct_pkg::car_ok(rear_d, N_CARS);

    dlct_link_mem #(
        .NUM_CARS (NUM_CARS),
        .AW       (AW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (link_wr),
        .i_wr_addr (front_wr_addr),
        .i_wr_data (front_wr_data),
        .i_rd_addr (front_rd_addr),
        .o_rd_data (front_d)
    );

    dlct_link_mem #(
        .NUM_CARS (NUM_CARS),
        .AW       (AW)
    ) u_rear (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (link_wr),
        .i_wr_addr (rear_wr_addr),
        .i_wr_data (rear_wr_data),
        .i_rd_addr (rear_rd_addr),
        .o_rd_data (rear_d)
    );

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_pos       = r_pos;
        n_out_valid = 1'b0;
        n_car_id    = r_car_id;
        n_position  = r_position;
        n_last      = r_last;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_mode == dlct_pkg::MODE_QUERY) &&
                    dlct_pkg::car_ok(i_car_a, N_CARS)) begin
                    n_state = S_FRONT;
                    n_cur   = i_car_a;
                    n_steps = '0;
                end
            end
            S_FRONT: begin
                if (front_go) begin
                    n_cur   = front_d;
                    n_steps = r_steps + SW'(1);
                end else begin
                    // r_cur is the head; its rear link is being read now
                    n_state = S_REAR;
                    n_pos   = '0;
                end
            end
            S_REAR: begin
                n_out_valid = 1'b1;
                n_car_id    = r_cur;
                n_position  = r_pos;
                n_last      = !rear_go;
                if (rear_go) begin
                    n_cur = rear_d;
                    n_pos = r_pos + dlct_pkg::POS_W'(1);
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_steps    <= n_steps;
        r_pos      <= n_pos;
        r_car_id   <= n_car_id;
        r_position <= n_position;
        r_last     <= n_last;
    end

    assign o_result_valid = r_out_valid;
    assign o_car_id       = r_car_id;
    assign o_position     = r_position;
    assign o_last_flag    = r_last;

    // a query always ends with a flagged last result as busy drops
    a_end_flagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_result_valid && o_last_flag))
        else $error("query ended without a last result");

    // results only come out of the rear walk
    a_from_rear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == S_REAR))
        else $error("result outside the rear walk");

    // a result that is not last leaves the walk running
    a_not_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last_flag) |-> busy)
        else $error("walk stopped before the last result");

    // positions count up within a run
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(o_result_valid) && !$past(o_last_flag)) |->
        (o_position == dlct_pkg::POS_W'($past(o_position) + 1'b1)))
        else $error("position did not advance by one");

    // link tables are only written while idle
    a_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        link_wr |-> !busy)
        else $error("link write during a walk");

endmodule

/* dv/tb_doubly_linked_chain_table_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_doubly_linked_chain_table_core
// drives connect, disconnect and query requests into the chain table and
// checks every emitted car, position and tail flag against a local link model
// ----------------------------------------------------------------------------
module tb_doubly_linked_chain_table_core;

    localparam int NUM_CARS    = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 2 * NUM_CARS + 8;
    localparam int DIR_ROWS    = 25;
    localparam int RAND_ITEMS  = 380;
    localparam logic [dlct_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [dlct_pkg::CAR_W-1:0] car;
        logic [dlct_pkg::POS_W-1:0] pos;
        logic                       tail;
    } t_chain_car;

    // typed rows carry their own expectation: t_one says one lone car comes back
    typedef struct packed {
        logic [dlct_pkg::MODE_W-1:0] mode;
        logic [dlct_pkg::CAR_W-1:0]  car_a;
        logic [dlct_pkg::CAR_W-1:0]  car_b;
        logic                        typed;
        logic                        t_one;
        logic [dlct_pkg::CAR_W-1:0]  t_car;
    } t_req_row;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [dlct_pkg::MODE_W-1:0] i_mode;
    logic [dlct_pkg::CAR_W-1:0]  i_car_a;
    logic [dlct_pkg::CAR_W-1:0]  i_car_b;
    logic                        o_result_valid;
    logic [dlct_pkg::CAR_W-1:0]  o_car_id;
    logic [dlct_pkg::POS_W-1:0]  o_position;
    logic                        o_last_flag;

    logic                        req_typed;
    logic                        req_t_one;
    logic [dlct_pkg::CAR_W-1:0]  req_t_car;

    logic [dlct_pkg::CAR_W-1:0]  front_tbl [0:NUM_CARS];
    logic [dlct_pkg::CAR_W-1:0]  rear_tbl  [0:NUM_CARS];
    t_chain_car                  exp_cars [$];
    logic [dlct_pkg::CAR_W-1:0]  car_pool [0:NUM_CARS-1];
    t_req_row                    directed_rows [DIR_ROWS];

    int n_requests  = 0;
    int n_mismatch  = 0;
    int n_counted   = 0;
    int quiet_count = 0;
    bit no_idle     = 1'b0;

    doubly_linked_chain_table_core #(
        .NUM_CARS(NUM_CARS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_car_a       (i_car_a),
        .i_car_b       (i_car_b),
        .o_result_valid(o_result_valid),
        .o_car_id      (o_car_id),
        .o_position    (o_position),
        .o_last_flag   (o_last_flag)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit in_range(input logic [dlct_pkg::CAR_W-1:0] c);
        return (c >= 1) && (c <= NUM_CARS);
    endfunction

    function automatic bit has_effect(input logic [dlct_pkg::MODE_W-1:0] mode,
                                      input logic [dlct_pkg::CAR_W-1:0] a,
                                      input logic [dlct_pkg::CAR_W-1:0] b);
        if (mode == dlct_pkg::MODE_CONNECT || mode == dlct_pkg::MODE_DISCONNECT)
            return in_range(a) && in_range(b);
        return (mode == dlct_pkg::MODE_QUERY) && in_range(a);
    endfunction

    // appends one expected car at the back of the queue
    function automatic void append_expect(input t_chain_car c);
        exp_cars = {exp_cars, c};
    endfunction

    // updates the link tables, or lists the chain that holds car a
    function automatic void link_or_list(input logic [dlct_pkg::MODE_W-1:0] mode,
                                         input logic [dlct_pkg::CAR_W-1:0] a,
                                         input logic [dlct_pkg::CAR_W-1:0] b);
        logic [dlct_pkg::CAR_W-1:0] cur;
        logic [dlct_pkg::CAR_W-1:0] nxt;
        int                         cnt;
        bit                         done;
        if (!has_effect(mode, a, b))
            return;
        if (mode == dlct_pkg::MODE_CONNECT) begin
            rear_tbl[a]  = b;
            front_tbl[b] = a;
        end else if (mode == dlct_pkg::MODE_DISCONNECT) begin
            rear_tbl[a]  = a;
            front_tbl[b] = b;
        end else begin
            cur = a;
            // front walk stops after NUM_CARS steps even on a ring
            for (int s = 0; s < NUM_CARS; s++) begin
                nxt = front_tbl[cur];
                if (nxt == cur || !in_range(nxt))
                    break;
                cur = nxt;
            end
            cnt  = 0;
            done = 1'b0;
            while (!done) begin
                nxt  = rear_tbl[cur];
                done = (cnt == NUM_CARS - 1) || (nxt == cur) || !in_range(nxt);
                append_expect('{cur, cnt[dlct_pkg::POS_W-1:0], done});
                cur = nxt;
                cnt++;
            end
        end
    endfunction

    function automatic void note_mismatch(input string what, input t_chain_car want,
                                          input t_chain_car got);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display({"mismatch (%s): want car %0d pos %0d tail %0b, ",
                      "got car %0d pos %0d tail %0b"},
                     what, want.car, want.pos, want.tail, got.car, got.pos, got.tail);
    endfunction

    // results first, so a request taken at the same edge queues behind them
    always @(posedge i_clk) begin
        t_chain_car got;
        t_chain_car want;
        if (i_rst_n) begin
            if (o_result_valid) begin
                got = '{o_car_id, o_position, o_last_flag};
                if (exp_cars.size() == 0) begin
                    note_mismatch("no result expected", '0, got);
                end else begin
                    want = exp_cars.pop_front();
                    if (got.car != want.car || got.pos != want.pos || got.tail != want.tail)
                        note_mismatch("field", want, got);
                end
            end
            if (start && !busy) begin
                n_requests++;
                if (req_typed) begin
                    if (req_t_one)
                        append_expect('{req_t_car, '0, 1'b1});
                end else begin
                    link_or_list(i_mode, i_car_a, i_car_b);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_result_valid || (start && !busy))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // all driving tasks start and end on a falling edge
    task automatic send_request(input logic [dlct_pkg::MODE_W-1:0] mode,
                                input logic [dlct_pkg::CAR_W-1:0] a,
                                input logic [dlct_pkg::CAR_W-1:0] b,
                                input logic typed = 1'b0,
                                input logic t_one = 1'b0,
                                input logic [dlct_pkg::CAR_W-1:0] t_car = '0);
        int taken;
        taken = n_requests;
        start     <= 1'b1;
        i_mode    <= mode;
        i_car_a   <= a;
        i_car_b   <= b;
        req_typed <= typed;
        req_t_one <= t_one;
        req_t_car <= t_car;
        do @(negedge i_clk); while (n_requests == taken);
        if (has_effect(mode, a, b))
            n_counted++;
    endtask

    task automatic idle_cycles(input int n);
        start   <= 1'b0;
        i_mode  <= dlct_pkg::MODE_W'($urandom_range(0, 3));
        i_car_a <= dlct_pkg::CAR_W'($urandom_range(0, 127));
        i_car_b <= dlct_pkg::CAR_W'($urandom_range(0, 127));
        repeat (n) @(negedge i_clk);
    endtask

    // each offered cycle is left idle with a chance of about one in five
    task automatic maybe_idle();
        while (!no_idle && $urandom_range(0, 99) < 19)
            idle_cycles(1);
    endtask

    task automatic hold_until_drained();
        start <= 1'b0;
        while (exp_cars.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic send_mixed(input logic [dlct_pkg::MODE_W-1:0] mode,
                              input logic [dlct_pkg::CAR_W-1:0] a,
                              input logic [dlct_pkg::CAR_W-1:0] b);
        send_request(mode, a, b);
        maybe_idle();
    endtask

    task automatic shuffle_pool();
        int j;
        logic [dlct_pkg::CAR_W-1:0] t;
        for (int k = 0; k < NUM_CARS; k++)
            car_pool[k] = dlct_pkg::CAR_W'(k + 1);
        for (int k = NUM_CARS - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = car_pool[k];
            car_pool[k] = car_pool[j];
            car_pool[j] = t;
        end
    endtask

    // builds one chain of distinct cars, queries it, optionally rings it, then clears it or cuts and requeries it
    task automatic chain_episode(input int len, input bit ring, input bit teardown);
        logic [dlct_pkg::CAR_W-1:0] b;
        shuffle_pool();
        for (int k = 0; k < len - 1; k++) begin
            b = car_pool[k + 1];
            // now and then a broken link request with an id out of range
            if ($urandom_range(0, 19) == 0)
                b = ($urandom_range(0, 1) != 0) ? dlct_pkg::CAR_W'(0)
                                                : dlct_pkg::CAR_W'($urandom_range(65, 127));
            send_mixed(dlct_pkg::MODE_CONNECT, car_pool[k], b);
        end
        repeat ($urandom_range(1, 2))
            send_mixed(dlct_pkg::MODE_QUERY, car_pool[$urandom_range(0, len - 1)],
                       dlct_pkg::CAR_W'($urandom_range(0, 127)));
        if (ring) begin
            send_mixed(dlct_pkg::MODE_CONNECT, car_pool[len - 1], car_pool[0]);
            repeat ($urandom_range(1, 2))
                send_mixed(dlct_pkg::MODE_QUERY, car_pool[$urandom_range(0, len - 1)],
                           dlct_pkg::CAR_W'($urandom_range(0, 127)));
        end
        if (teardown) begin
            for (int k = 0; k < len - 1; k++)
                send_mixed(dlct_pkg::MODE_DISCONNECT, car_pool[k], car_pool[k + 1]);
            if (ring)
                send_mixed(dlct_pkg::MODE_DISCONNECT, car_pool[len - 1], car_pool[0]);
        end else if (len > 2) begin
            send_mixed(dlct_pkg::MODE_DISCONNECT, car_pool[0], car_pool[1]);
            send_mixed(dlct_pkg::MODE_QUERY, car_pool[$urandom_range(0, len - 1)], '0);
        end
    endtask

    initial begin
        int episode;
        int pick;
        int len;
        start     = 1'b0;
        i_mode    = dlct_pkg::MODE_CONNECT;
        i_car_a   = '0;
        i_car_b   = '0;
        req_typed = 1'b0;
        req_t_one = 1'b0;
        req_t_car = '0;
        i_rst_n   = 1'b0;
        for (int k = 0; k <= NUM_CARS; k++) begin
            front_tbl[k] = dlct_pkg::CAR_W'(k);
            rear_tbl[k]  = dlct_pkg::CAR_W'(k);
        end

        directed_rows = '{
            '{dlct_pkg::MODE_QUERY,      7'd1,   7'd0,   1'b1, 1'b1, 7'd1},
            '{dlct_pkg::MODE_QUERY,      7'd64,  7'd0,   1'b1, 1'b1, 7'd64},
            '{dlct_pkg::MODE_QUERY,      7'd0,   7'd0,   1'b1, 1'b0, 7'd0},
            '{dlct_pkg::MODE_QUERY,      7'd65,  7'd0,   1'b1, 1'b0, 7'd0},
            '{dlct_pkg::MODE_QUERY,      7'd127, 7'd127, 1'b1, 1'b0, 7'd0},
            '{MODE_UNUSED,               7'd5,   7'd6,   1'b1, 1'b0, 7'd0},
            '{dlct_pkg::MODE_CONNECT,    7'd0,   7'd5,   1'b1, 1'b0, 7'd0},
            '{dlct_pkg::MODE_CONNECT,    7'd5,   7'd65,  1'b1, 1'b0, 7'd0},
            '{dlct_pkg::MODE_DISCONNECT, 7'd127, 7'd0,   1'b1, 1'b0, 7'd0},
            '{dlct_pkg::MODE_QUERY,      7'd5,   7'd0,   1'b1, 1'b1, 7'd5},
            '{dlct_pkg::MODE_CONNECT,    7'd1,   7'd2,   1'b0, 1'b0, 7'd0},
            '{dlct_pkg::MODE_CONNECT,    7'd2,   7'd3,   1'b0, 1'b0, 7'd0},
            '{dlct_pkg::MODE_CONNECT,    7'd3,   7'd64,  1'b0, 1'b0, 7'd0},
            '{dlct_pkg::MODE_QUERY,      7'd3,   7'd0,   1'b0, 1'b0, 7'd0},
            '{dlct_pkg::MODE_QUERY,      7'd64,  7'd0,   1'b0, 1'b0, 7'd0},
            '{dlct_pkg::MODE_QUERY,      7'd1,   7'd0,   1'b0, 1'b0, 7'd0},
            '{dlct_pkg::MODE_DISCONNECT, 7'd2,   7'd3,   1'b0, 1'b0, 7'd0},
            '{dlct_pkg::MODE_QUERY,      7'd64,  7'd0,   1'b0, 1'b0, 7'd0},
            '{dlct_pkg::MODE_CONNECT,    7'd2,   7'd3,   1'b0, 1'b0, 7'd0},
            '{dlct_pkg::MODE_CONNECT,    7'd64,  7'd1,   1'b0, 1'b0, 7'd0},
            '{dlct_pkg::MODE_QUERY,      7'd2,   7'd0,   1'b0, 1'b0, 7'd0},
            '{dlct_pkg::MODE_CONNECT,    7'd7,   7'd7,   1'b0, 1'b0, 7'd0},
            '{dlct_pkg::MODE_QUERY,      7'd7,   7'd0,   1'b1, 1'b1, 7'd7},
            '{dlct_pkg::MODE_DISCONNECT, 7'd64,  7'd1,   1'b0, 1'b0, 7'd0},
            '{dlct_pkg::MODE_QUERY,      7'd64,  7'd0,   1'b0, 1'b0, 7'd0}
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[r]) begin
            send_request(directed_rows[r].mode, directed_rows[r].car_a,
                         directed_rows[r].car_b, directed_rows[r].typed,
                         directed_rows[r].t_one, directed_rows[r].t_car);
            maybe_idle();
        end
        hold_until_drained();

        // leave the directed chain behind as random clutter, then a full ring
        n_counted = 0;
        chain_episode(NUM_CARS, 1'b1, 1'b1);
        episode = 0;
        while (n_counted < RAND_ITEMS) begin
            episode++;
            no_idle = (n_counted >= 180) && (n_counted < 280);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, NUM_CARS)
                                                  : $urandom_range(2, 10);
                chain_episode(len, $urandom_range(0, 99) < 15, $urandom_range(0, 9) < 6);
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4))
                    send_mixed(dlct_pkg::MODE_W'($urandom_range(0, 3)),
                               dlct_pkg::CAR_W'($urandom_range(0, 127)),
                               dlct_pkg::CAR_W'($urandom_range(0, 127)));
            end else begin
                repeat ($urandom_range(2, 5)) begin
                    if ($urandom_range(0, 1) != 0)
                        send_mixed(dlct_pkg::MODE_DISCONNECT,
                                   dlct_pkg::CAR_W'($urandom_range(1, NUM_CARS)),
                                   dlct_pkg::CAR_W'($urandom_range(1, NUM_CARS)));
                    else
                        send_mixed(dlct_pkg::MODE_QUERY,
                                   dlct_pkg::CAR_W'($urandom_range(1, NUM_CARS)),
                                   dlct_pkg::CAR_W'($urandom_range(0, 127)));
                end
            end
            if (episode % 8 == 0)
                hold_until_drained();
        end

        hold_until_drained();
        if (n_mismatch == 0 && exp_cars.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
